[sv/kbc_pkg.sv]
package kbc_pkg;

	localparam logic [2:0] CMD_CMD_WR  = 3'd0;
	localparam logic [2:0] CMD_DATA_WR = 3'd1;
	localparam logic [2:0] CMD_STAT_RD = 3'd2;
	localparam logic [2:0] CMD_DATA_RD = 3'd3;
	localparam logic [2:0] CMD_KBD_LVL = 3'd4;
	localparam logic [2:0] CMD_AUX_LVL = 3'd5;

	localparam logic [2:0] ACT_NONE       = 3'd0;
	localparam logic [2:0] ACT_QUEUE_KBD  = 3'd1;
	localparam logic [2:0] ACT_QUEUE_AUX  = 3'd2;
	localparam logic [2:0] ACT_SEND_KBD   = 3'd3;
	localparam logic [2:0] ACT_SEND_MOUSE = 3'd4;
	localparam logic [2:0] ACT_READ_KBD   = 3'd5;
	localparam logic [2:0] ACT_READ_MOUSE = 3'd6;

	localparam logic [7:0] OP_NONE       = 8'h00;
	localparam logic [7:0] OP_READ_MODE  = 8'h20;
	localparam logic [7:0] OP_WRITE_MODE = 8'h60;
	localparam logic [7:0] OP_AUX_DIS    = 8'hA7;
	localparam logic [7:0] OP_AUX_EN     = 8'hA8;
	localparam logic [7:0] OP_AUX_TEST   = 8'hA9;
	localparam logic [7:0] OP_SELF_TEST  = 8'hAA;
	localparam logic [7:0] OP_KBD_TEST   = 8'hAB;
	localparam logic [7:0] OP_KBD_DIS    = 8'hAD;
	localparam logic [7:0] OP_KBD_EN     = 8'hAE;
	localparam logic [7:0] OP_READ_INP   = 8'hC0;
	localparam logic [7:0] OP_READ_OUTP  = 8'hD0;
	localparam logic [7:0] OP_WRITE_OUTP = 8'hD1;
	localparam logic [7:0] OP_WRITE_KOBUF = 8'hD2;
	localparam logic [7:0] OP_WRITE_AOBUF = 8'hD3;
	localparam logic [7:0] OP_WRITE_AUX  = 8'hD4;
	localparam logic [7:0] OP_DIS_A20    = 8'hDD;
	localparam logic [7:0] OP_EN_A20     = 8'hDF;
	localparam logic [7:0] OP_RESET      = 8'hFE;
	localparam logic [7:0] OP_NOP        = 8'hFF;

	localparam logic [7:0] SELF_TEST_OK = 8'h55;
	localparam logic [7:0] MODE_RESET   = 8'h03;
	localparam logic [7:0] STATUS_RESET = 8'h18;

	localparam logic [1:0] PEND_KBD = 2'b01;
	localparam logic [1:0] PEND_AUX = 2'b10;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] value;
		logic       level;
	} kbc_req_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_out;
		logic       irq_keyboard;
		logic       irq_aux;
		logic       translate;
		logic       translate_update;
		logic       reset_request;
		logic       unsupported;
	} kbc_rsp_t;

endpackage

[sv/ps2_keyboard_controller_core.sv]
// i8042-style keyboard controller core. One port access per transaction on
// req (command/data write, status/data read, or a buffer level change); one
// result per transaction on rsp. Sustains one transaction per clock while
// rsp is not stalled. Stages: input register, then decode and state update
// into the result register. Controller state changes when the result register
// loads, so accesses take effect strictly in order. A20 is not modeled.
module ps2_keyboard_controller_core import kbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  kbc_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output kbc_rsp_t rsp
);

	logic     valid_s1;
	kbc_req_t req_s1;
	logic     adv;
	kbc_rsp_t res;

	assign adv       = valid_s1 & (~rsp_valid | ~rsp_stall);
	assign req_stall = valid_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	kbc_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (req_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (!rsp_valid || !rsp_stall) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp <= res;
		end
	end

	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid)
		else $error("result register did not load");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid && rsp_stall)
		else $error("input stalled without a blocked transaction");

	a_irq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.irq_keyboard && rsp.irq_aux))
		else $error("both interrupt lines active");

	a_unsup_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.unsupported |-> rsp.action == ACT_NONE && !rsp.reset_request)
		else $error("unsupported command produced an action");

endmodule

[sv/kbc_exec.sv]
module kbc_exec import kbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  kbc_req_t item,
	output kbc_rsp_t res
);

	logic [7:0] mode_q, mode_n;
	logic [7:0] status_q, status_n;
	logic [7:0] pend_cmd_q, pend_cmd_n;
	logic [1:0] pend_q, pend_n;

	function automatic logic [7:0] refresh(input logic [7:0] st, input logic [1:0] pend);
		logic [7:0] r;
		r = st & 8'hDE;
		r[0] = (pend != 2'b00);
		r[5] = (pend == PEND_AUX);
		return r;
	endfunction

	always_comb begin
		mode_n     = mode_q;
		status_n   = status_q;
		pend_cmd_n = pend_cmd_q;
		pend_n     = pend_q;
		res        = '0;
		unique case (item.command)
			CMD_CMD_WR: begin
				unique case (item.value)
					OP_READ_MODE: begin
						res.action   = ACT_QUEUE_KBD;
						res.byte_out = mode_q;
					end
					OP_WRITE_MODE, OP_WRITE_OUTP, OP_WRITE_KOBUF, OP_WRITE_AOBUF,
					OP_WRITE_AUX: pend_cmd_n = item.value;
					OP_AUX_DIS: mode_n[5] = 1'b1;
					OP_AUX_EN:  mode_n[5] = 1'b0;
					OP_AUX_TEST, OP_KBD_TEST, OP_READ_INP: res.action = ACT_QUEUE_KBD;
					OP_SELF_TEST: begin
						status_n[2]  = 1'b1;
						res.action   = ACT_QUEUE_KBD;
						res.byte_out = SELF_TEST_OK;
					end
					OP_KBD_DIS: begin
						mode_n[4] = 1'b1;
						status_n  = refresh(status_q, pend_q);
					end
					OP_KBD_EN: begin
						mode_n[4] = 1'b0;
						status_n  = refresh(status_q, pend_q);
					end
					OP_READ_OUTP: begin
						res.action   = ACT_QUEUE_KBD;
						res.byte_out = {2'b00, status_q[5], status_q[0], 4'b0011};
					end
					OP_DIS_A20, OP_EN_A20, OP_NOP: ;
					OP_RESET: res.reset_request = 1'b1;
					default: res.unsupported = 1'b1;
				endcase
			end
			CMD_DATA_WR: begin
				unique case (pend_cmd_q)
					OP_NONE: begin
						res.action   = ACT_SEND_KBD;
						res.byte_out = item.value;
					end
					OP_WRITE_MODE: begin
						mode_n               = item.value;
						res.translate_update = 1'b1;
						status_n             = refresh(status_q, pend_q);
					end
					OP_WRITE_KOBUF: begin
						res.action   = ACT_QUEUE_KBD;
						res.byte_out = item.value;
					end
					OP_WRITE_AOBUF: begin
						res.action   = ACT_QUEUE_AUX;
						res.byte_out = item.value;
					end
					OP_WRITE_OUTP: res.reset_request = ~item.value[0];
					OP_WRITE_AUX: begin
						res.action   = ACT_SEND_MOUSE;
						res.byte_out = item.value;
					end
					default: ;
				endcase
				pend_cmd_n = OP_NONE;
			end
			CMD_STAT_RD: res.byte_out = status_q;
			CMD_DATA_RD: res.action = (pend_q == PEND_AUX) ? ACT_READ_MOUSE : ACT_READ_KBD;
			CMD_KBD_LVL: begin
				pend_n[0] = item.level;
				status_n  = refresh(status_q, pend_n);
			end
			CMD_AUX_LVL: begin
				pend_n[1] = item.level;
				status_n  = refresh(status_q, pend_n);
			end
			default: ;
		endcase
		res.irq_keyboard = pend_n[0] & mode_n[0] & ~mode_n[4];
		res.irq_aux      = (pend_n == PEND_AUX) & mode_n[1];
		res.translate    = mode_n[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RESET;
			status_q   <= STATUS_RESET;
			pend_cmd_q <= OP_NONE;
			pend_q     <= 2'b00;
		end else if (en) begin
			mode_q     <= mode_n;
			status_q   <= status_n;
			pend_cmd_q <= pend_cmd_n;
			pend_q     <= pend_n;
		end
	end

endmodule

[tb/tb_ps2_keyboard_controller_core.sv]
`timescale 1ns / 1ps

module tb_ps2_keyboard_controller_core;
	import kbc_pkg::*;

	localparam int PERIOD      = 8;
	localparam int RESET_LEN   = 12;
	localparam int ITEMS       = 550;
	localparam int BURST_ITEMS = 40;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN       = 10;
	localparam int LIMIT       = 400000;

	// command codes beyond the defined accesses
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic [7:0] OUTP_BASE  = 8'h03;

	typedef struct {
		kbc_req_t req;
		bit       fixed;
		kbc_rsp_t rsp;
	} access_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	kbc_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	kbc_rsp_t rsp;

	logic [7:0] kbc_mode;
	logic [7:0] kbc_status;
	logic [7:0] kbc_wr_cmd;
	logic [1:0] kbc_pend;

	kbc_rsp_t    expected_rsp_q[$];
	access_row_t access_table[$];
	int          accepted = 0;
	int          fails = 0;
	int          cycles = 0;
	bit          hold_rsp = 1'b0;

	ps2_keyboard_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	function automatic int sender_gap();
		if ($urandom_range(0, 99) < 55)
			return 0;
		return idle_len();
	endfunction

	function automatic void refresh_status_bits();
		kbc_status[0] = (kbc_pend != 2'b00);
		kbc_status[5] = (kbc_pend == PEND_AUX);
	endfunction

	function automatic kbc_rsp_t controller_access(kbc_req_t r);
		kbc_rsp_t o;
		o = '0;
		case (r.command)
		CMD_CMD_WR: begin
			case (r.value)
			OP_READ_MODE: begin
				o.action = ACT_QUEUE_KBD;
				o.byte_out = kbc_mode;
			end
			OP_WRITE_MODE, OP_WRITE_OUTP, OP_WRITE_KOBUF, OP_WRITE_AOBUF, OP_WRITE_AUX:
				kbc_wr_cmd = r.value;
			OP_AUX_DIS: kbc_mode[5] = 1'b1;
			OP_AUX_EN: kbc_mode[5] = 1'b0;
			OP_AUX_TEST, OP_KBD_TEST, OP_READ_INP: o.action = ACT_QUEUE_KBD;
			OP_SELF_TEST: begin
				kbc_status[2] = 1'b1;
				o.action = ACT_QUEUE_KBD;
				o.byte_out = SELF_TEST_OK;
			end
			OP_KBD_DIS: begin
				kbc_mode[4] = 1'b1;
				refresh_status_bits();
			end
			OP_KBD_EN: begin
				kbc_mode[4] = 1'b0;
				refresh_status_bits();
			end
			OP_READ_OUTP: begin
				o.action = ACT_QUEUE_KBD;
				o.byte_out = OUTP_BASE | {2'b00, kbc_status[5], kbc_status[0], 4'b0000};
			end
			OP_DIS_A20, OP_EN_A20, OP_NOP: ;
			OP_RESET: o.reset_request = 1'b1;
			default: o.unsupported = 1'b1;
			endcase
		end
		CMD_DATA_WR: begin
			case (kbc_wr_cmd)
			OP_NONE: begin
				o.action = ACT_SEND_KBD;
				o.byte_out = r.value;
			end
			OP_WRITE_MODE: begin
				kbc_mode = r.value;
				o.translate_update = 1'b1;
				refresh_status_bits();
			end
			OP_WRITE_KOBUF: begin
				o.action = ACT_QUEUE_KBD;
				o.byte_out = r.value;
			end
			OP_WRITE_AOBUF: begin
				o.action = ACT_QUEUE_AUX;
				o.byte_out = r.value;
			end
			OP_WRITE_OUTP: o.reset_request = ~r.value[0];
			OP_WRITE_AUX: begin
				o.action = ACT_SEND_MOUSE;
				o.byte_out = r.value;
			end
			default: ;
			endcase
			kbc_wr_cmd = OP_NONE;
		end
		CMD_STAT_RD: o.byte_out = kbc_status;
		CMD_DATA_RD: o.action = (kbc_pend == PEND_AUX) ? ACT_READ_MOUSE : ACT_READ_KBD;
		CMD_KBD_LVL: begin
			kbc_pend[0] = r.level;
			refresh_status_bits();
		end
		CMD_AUX_LVL: begin
			kbc_pend[1] = r.level;
			refresh_status_bits();
		end
		default: ;
		endcase
		o.irq_keyboard = kbc_pend[0] && kbc_mode[0] && !kbc_mode[4];
		o.irq_aux = (kbc_pend == PEND_AUX) && kbc_mode[1];
		o.translate = kbc_mode[6];
		return o;
	endfunction

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
		fails++;
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, field, got, want);
	endtask

	task automatic check_result(kbc_rsp_t got, kbc_rsp_t want);
		if (got.action !== want.action)
			flag_mismatch("action", 32'(got.action), 32'(want.action));
		if (got.byte_out !== want.byte_out)
			flag_mismatch("byte_out", 32'(got.byte_out), 32'(want.byte_out));
		if (got.irq_keyboard !== want.irq_keyboard)
			flag_mismatch("irq_keyboard", 32'(got.irq_keyboard), 32'(want.irq_keyboard));
		if (got.irq_aux !== want.irq_aux)
			flag_mismatch("irq_aux", 32'(got.irq_aux), 32'(want.irq_aux));
		if (got.translate !== want.translate)
			flag_mismatch("translate", 32'(got.translate), 32'(want.translate));
		if (got.translate_update !== want.translate_update)
			flag_mismatch("translate_update", 32'(got.translate_update),
				32'(want.translate_update));
		if (got.reset_request !== want.reset_request)
			flag_mismatch("reset_request", 32'(got.reset_request), 32'(want.reset_request));
		if (got.unsupported !== want.unsupported)
			flag_mismatch("unsupported", 32'(got.unsupported), 32'(want.unsupported));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0)
				flag_mismatch("unexpected result", 32'(rsp), '0);
			else
				check_result(rsp, expected_rsp_q.pop_front());
		end
	end

	// receiver side: random stalls, or one long hold-off on request
	initial begin
		int run;
		bit stalled;
		bit held;
		run = 0;
		stalled = 1'b0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp && !held) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				run = 0;
			end else begin
				if (run == 0) begin
					stalled = ($urandom_range(0, 99) < 30);
					run = stalled ? idle_len() : $urandom_range(1, 24);
				end
				rsp_stall <= stalled;
				run--;
			end
		end
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_ps2_keyboard_controller_core: FAIL");
		$finish;
	end

	task automatic plan_access(logic [2:0] cmd, logic [7:0] val, logic lvl, bit fixed,
			kbc_rsp_t want);
		access_row_t row;
		row.req.command = cmd;
		row.req.value = val;
		row.req.level = lvl;
		row.fixed = fixed;
		row.rsp = want;
		access_table.push_back(row);
	endtask

	function automatic kbc_rsp_t rsp_of(logic [2:0] act, logic [7:0] b, logic ik, logic im,
			logic tr, logic tu, logic rr, logic un);
		kbc_rsp_t o;
		o.action = act;
		o.byte_out = b;
		o.irq_keyboard = ik;
		o.irq_aux = im;
		o.translate = tr;
		o.translate_update = tu;
		o.reset_request = rr;
		o.unsupported = un;
		return o;
	endfunction

	task automatic offer(kbc_req_t r, bit fixed, kbc_rsp_t want);
		kbc_rsp_t predicted;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predicted = controller_access(r);
		expected_rsp_q.push_back(fixed ? want : predicted);
		accepted++;
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_access(bit burst);
		kbc_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.value = 8'($urandom_range(0, 255));
		r.level = 1'($urandom_range(0, 1));
		r.command = CMD_CMD_WR;
		if (pick < 25) begin
			case ($urandom_range(0, 4))
			0: r.value = OP_WRITE_MODE;
			1: r.value = OP_WRITE_OUTP;
			2: r.value = OP_WRITE_KOBUF;
			3: r.value = OP_WRITE_AOBUF;
			default: r.value = OP_WRITE_AUX;
			endcase
			offer(r, 1'b0, '0);
			if (!burst)
				pause_sender(sender_gap());
			r.command = CMD_DATA_WR;
			r.value = 8'($urandom_range(0, 255));
		end else if (pick < 40) begin
			r.command = ($urandom_range(0, 1) != 0) ? CMD_KBD_LVL : CMD_AUX_LVL;
		end else if (pick < 50) begin
			r.command = CMD_STAT_RD;
		end else if (pick < 60) begin
			r.command = CMD_DATA_RD;
		end else if (pick < 80) begin
			case ($urandom_range(0, 13))
			0: r.value = OP_READ_MODE;
			1: r.value = OP_AUX_DIS;
			2: r.value = OP_AUX_EN;
			3: r.value = OP_AUX_TEST;
			4: r.value = OP_SELF_TEST;
			5: r.value = OP_KBD_TEST;
			6: r.value = OP_KBD_DIS;
			7: r.value = OP_KBD_EN;
			8: r.value = OP_READ_INP;
			9: r.value = OP_READ_OUTP;
			10: r.value = OP_DIS_A20;
			11: r.value = OP_EN_A20;
			12: r.value = OP_RESET;
			default: r.value = OP_NOP;
			endcase
		end else if (pick < 90) begin
			r.command = CMD_CMD_WR;
		end else if (pick < 97) begin
			r.command = CMD_DATA_WR;
		end else begin
			r.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
		end
		offer(r, 1'b0, '0);
		if (!burst)
			pause_sender(sender_gap());
	endtask

	initial begin
		kbc_mode = MODE_RESET;
		kbc_status = STATUS_RESET;
		kbc_wr_cmd = OP_NONE;
		kbc_pend = 2'b00;

		plan_access(CMD_STAT_RD, 8'h00, 1'b0, 1'b1,
			rsp_of(ACT_NONE, STATUS_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		plan_access(CMD_CMD_WR, OP_READ_MODE, 1'b0, 1'b1,
			rsp_of(ACT_QUEUE_KBD, MODE_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		plan_access(CMD_CMD_WR, OP_SELF_TEST, 1'b1, 1'b1,
			rsp_of(ACT_QUEUE_KBD, SELF_TEST_OK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		plan_access(CMD_STAT_RD, 8'hFF, 1'b1, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_RESET, 1'b0, 1'b1,
			rsp_of(ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
		plan_access(CMD_CMD_WR, 8'h00, 1'b0, 1'b1,
			rsp_of(ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
		plan_access(CMD_CMD_WR, OP_NOP, 1'b0, 1'b1,
			rsp_of(ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		plan_access(CMD_CMD_WR, OP_WRITE_MODE, 1'b0, 1'b0, '0);
		plan_access(CMD_DATA_WR, 8'hFF, 1'b0, 1'b1,
			rsp_of(ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
		plan_access(CMD_KBD_LVL, 8'h00, 1'b1, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_KBD_EN, 1'b0, 1'b0, '0);
		plan_access(CMD_AUX_LVL, 8'h00, 1'b1, 1'b0, '0);
		plan_access(CMD_DATA_RD, 8'h00, 1'b0, 1'b0, '0);
		plan_access(CMD_KBD_LVL, 8'hFF, 1'b0, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_READ_OUTP, 1'b0, 1'b0, '0);
		plan_access(CMD_DATA_RD, 8'h00, 1'b0, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_AUX_DIS, 1'b0, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_KBD_DIS, 1'b0, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_AUX_EN, 1'b0, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_WRITE_OUTP, 1'b0, 1'b0, '0);
		plan_access(CMD_DATA_WR, 8'hFE, 1'b0, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_WRITE_AOBUF, 1'b0, 1'b0, '0);
		plan_access(CMD_DATA_WR, 8'h00, 1'b0, 1'b0, '0);
		plan_access(CMD_CMD_WR, OP_WRITE_AUX, 1'b0, 1'b0, '0);
		plan_access(CMD_DATA_WR, 8'h80, 1'b0, 1'b0, '0);
		plan_access(CMD_DATA_WR, 8'h7F, 1'b0, 1'b0, '0);
		plan_access(CMD_SPARE6, 8'hFF, 1'b1, 1'b0, '0);
		plan_access(CMD_SPARE7, 8'h00, 1'b0, 1'b0, '0);

		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (access_table[i]) begin
			offer(access_table[i].req, access_table[i].fixed, access_table[i].rsp);
			pause_sender(sender_gap());
		end

		// back-to-back transactions against a long receiver hold-off
		hold_rsp = 1'b1;
		repeat (BURST_ITEMS) random_access(1'b1);

		// drain fully before resuming
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		@(posedge clk);

		while (accepted < ITEMS)
			random_access(1'b0);

		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0)
			$display("tb_ps2_keyboard_controller_core: PASS");
		else
			$display("tb_ps2_keyboard_controller_core: FAIL");
		$finish;
	end

endmodule
